// File: hw/rtl/crc32_frame_checker_unit_defines.svh
// Assertion macros for the frame checker's port-level checker.
// Needs nothing else; the checker includes it by name.
`ifndef CRC32_FRAME_CHECKER_UNIT_DEFINES_SVH
`define CRC32_FRAME_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRC32FC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame checker assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRC32FC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame checker assertion failed");

`endif

// File: hw/rtl/crc32fc_pkg.sv
// Package for the CRC-32 frame checker: sizes, verdict codes and the CRC byte step.
// Depends on nothing; used by the output interface, the top level and the checker.
package crc32fc_pkg;

  localparam int unsigned MaxPayload  = 1024;
  localparam int unsigned SeqBytes    = 4;
  localparam int unsigned HeaderBytes = 8;
  // The byte counter saturates one past the longest legal frame.
  localparam int unsigned PosLimit    = HeaderBytes + MaxPayload + 1;
  localparam int unsigned PosW        = $clog2(PosLimit + 1);
  localparam int unsigned PayLenW     = 11;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    VerdictAccept   = 2'd0,
    VerdictMismatch = 2'd1,
    VerdictShort    = 2'd2,
    VerdictLong     = 2'd3
  } verdict_e;

  // One byte of the reflected CRC-32, unrolled over its eight bits.
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/crc32fc_in_if.sv
// Input channel of the frame checker: one frame byte and its end-of-frame flag.
// Depends on nothing.
interface crc32fc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

// File: hw/rtl/crc32fc_out_if.sv
// Output channel of the frame checker: one verdict per frame.
// Depends on crc32fc_pkg for the length field width.
interface crc32fc_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     verdict;
  logic [31:0]                    ack_sequence;
  logic [crc32fc_pkg::PayLenW-1:0] payload_bytes;

  modport source (output valid, output verdict, output ack_sequence,
                  output payload_bytes, input ready);
  modport sink (input valid, input verdict, input ack_sequence,
                input payload_bytes, output ready);
endinterface

// File: hw/rtl/crc32_frame_checker_unit.sv
// CRC-32 frame checker. A frame's last byte passes through the input register, and its verdict
// then waits in the result register. Throughput: one byte per cycle, sustained, set by the
// byte-wide CRC update between the input and state registers; a waiting verdict holds
// back only the next frame's last byte. Reset (rst_ni, asynchronous, active low) empties
// both registers and returns the frame state to its start values; each frame end does
// the same for the frame state. Depends on crc32fc_pkg, crc32fc_in_if and crc32fc_out_if.
module crc32_frame_checker_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  crc32fc_in_if.sink           in_i,
  crc32fc_out_if.source        out_o
);

  localparam int unsigned PosW = crc32fc_pkg::PosW;

  // Input register. It decouples the upstream handshake from the frame state.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;

  // Frame state, one set for the frame now being received.
  logic [PosW-1:0] pos_q, pos_d;
  logic [31:0]     seq_q, seq_d;
  logic [31:0]     chk_q, chk_d;
  logic [31:0]     crc_q, crc_d;

  // Result register. It holds a verdict until downstream takes it.
  logic                                out_vld_q;
  crc32fc_pkg::verdict_e               verdict_q, verdict_d;
  logic [31:0]                         ack_seq_q, ack_seq_d;
  logic [crc32fc_pkg::PayLenW-1:0]     plen_q, plen_d;

  logic step;
  logic in_ready;
  logic [PosW-1:0] pos_inc;

  // A byte in the input register is processed when it does not produce a result,
  // or when the result register is free or is being emptied this cycle.
  assign step     = in_vld_q && (!in_end_q || !out_vld_q || out_o.ready);
  assign in_ready = !in_vld_q || step;
  assign in_i.ready = in_ready;

  always_comb begin
    seq_d = seq_q;
    chk_d = chk_q;
    crc_d = crc_q;

    // Header bytes go into their byte lane; payload bytes feed the CRC until the
    // payload limit is reached, after which they are only counted.
    if (pos_q < PosW'(crc32fc_pkg::SeqBytes)) begin
      seq_d[8*pos_q[1:0] +: 8] = in_byte_q;
    end else if (pos_q < PosW'(crc32fc_pkg::HeaderBytes)) begin
      chk_d[8*pos_q[1:0] +: 8] = in_byte_q;
    end else if (pos_q < PosW'(crc32fc_pkg::HeaderBytes + crc32fc_pkg::MaxPayload)) begin
      crc_d = crc32fc_pkg::crc_byte(crc_q, in_byte_q);
    end

    // The counter saturates one past the largest legal frame length.
    if (pos_q < PosW'(crc32fc_pkg::PosLimit)) begin
      pos_inc = pos_q + PosW'(1);
    end else begin
      pos_inc = pos_q;
    end

    // A frame end returns the byte counter to its start value.
    if (in_end_q) begin
      pos_d = '0;
    end else begin
      pos_d = pos_inc;
    end
  end

  // Verdict for the frame, judged on the state as it stands after the last byte.
  always_comb begin
    if (pos_inc < PosW'(crc32fc_pkg::HeaderBytes)) begin
      verdict_d = crc32fc_pkg::VerdictShort;
      ack_seq_d = '0;
      plen_d    = '0;
    end else if (pos_inc > PosW'(crc32fc_pkg::HeaderBytes + crc32fc_pkg::MaxPayload)) begin
      verdict_d = crc32fc_pkg::VerdictLong;
      ack_seq_d = seq_d;
      plen_d    = crc32fc_pkg::PayLenW'(crc32fc_pkg::MaxPayload);
    end else begin
      ack_seq_d = seq_d;
      plen_d    = crc32fc_pkg::PayLenW'(pos_inc - PosW'(crc32fc_pkg::HeaderBytes));
      if (~crc_d == chk_d) begin
        verdict_d = crc32fc_pkg::VerdictAccept;
      end else begin
        verdict_d = crc32fc_pkg::VerdictMismatch;
      end
    end
  end

  // Input register control and payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_byte_q <= in_i.rx_byte;
      in_end_q  <= in_i.frame_end;
    end
  end

  // Frame state. On a frame end everything returns to its reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      seq_q <= '0;
      chk_q <= '0;
      crc_q <= crc32fc_pkg::CrcInit;
    end else if (step) begin
      pos_q <= pos_d;
      if (in_end_q) begin
        seq_q <= '0;
        chk_q <= '0;
        crc_q <= crc32fc_pkg::CrcInit;
      end else begin
        seq_q <= seq_d;
        chk_q <= chk_d;
        crc_q <= crc_d;
      end
    end
  end

  // Result register control and payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && in_end_q) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_end_q) begin
      verdict_q <= verdict_d;
      ack_seq_q <= ack_seq_d;
      plen_q    <= plen_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.verdict       = verdict_q;
  assign out_o.ack_sequence  = ack_seq_q;
  assign out_o.payload_bytes = plen_q;

endmodule

// File: hw/rtl/crc32fc_checker.sv
// Port-level assertions for the frame checker, bound to its top level.
// Depends on crc32fc_pkg and the assertion macros header.
`include "crc32_frame_checker_unit_defines.svh"

module crc32fc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [1:0]                       verdict_i,
  input logic [31:0]                      ack_sequence_i,
  input logic [crc32fc_pkg::PayLenW-1:0]  payload_bytes_i
);

  logic is_short;
  logic is_long;
  logic is_judged;

  assign is_short  = out_valid_i && (verdict_i == crc32fc_pkg::VerdictShort);
  assign is_long   = out_valid_i && (verdict_i == crc32fc_pkg::VerdictLong);
  assign is_judged = out_valid_i && ((verdict_i == crc32fc_pkg::VerdictAccept) ||
                                     (verdict_i == crc32fc_pkg::VerdictMismatch));

  // A stalled verdict stays and does not change.
  `CRC32FC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(verdict_i) && $stable(ack_sequence_i) && $stable(payload_bytes_i))

  // A short frame reports neither a sequence number nor a length.
  `CRC32FC_ASSERT_NOW(a_short_empty, clk_i, rst_ni, is_short, (ack_sequence_i == 32'd0) && (payload_bytes_i == '0))

  // An overlong frame reports the length limit.
  `CRC32FC_ASSERT_NOW(a_long_len, clk_i, rst_ni, is_long, payload_bytes_i == crc32fc_pkg::PayLenW'(crc32fc_pkg::MaxPayload))

  // A judged frame never exceeds the payload limit.
  `CRC32FC_ASSERT_NOW(a_judged_len, clk_i, rst_ni, is_judged, payload_bytes_i <= crc32fc_pkg::PayLenW'(crc32fc_pkg::MaxPayload))

endmodule

bind crc32_frame_checker_unit crc32fc_checker u_crc32fc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .verdict_i      (out_o.verdict),
  .ack_sequence_i (out_o.ack_sequence),
  .payload_bytes_i(out_o.payload_bytes)
);

// File: tb/tb_crc32_frame_checker_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for crc32_frame_checker_unit: random frames in, verdicts checked.
// Depends on crc32fc_pkg, crc32fc_in_if, crc32fc_out_if and the unit itself.
module tb_crc32_frame_checker_unit;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  typedef struct {
    crc32fc_pkg::verdict_e                verdict;
    logic [31:0]                          seq;
    logic [crc32fc_pkg::PayLenW-1:0]      len;
  } verdict_rec_t;

  typedef enum int {
    FrameGood,
    FrameBadCrc,
    FrameShort,
    FrameNoise
  } frame_kind_e;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned PhaseBudget   = 110;

  logic clk_i;
  logic rst_ni;

  crc32fc_in_if  in_if ();
  crc32fc_out_if out_if ();

  crc32_frame_checker_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  frame_byte_t  pending_bytes[$];
  verdict_rec_t expected_verdicts[$];
  int           bytes_outstanding;
  int           queued_total;
  int           failures;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  int unsigned  stall_cycles;

  // Shadow of the frame state inside the unit.
  logic [crc32fc_pkg::PosW-1:0] frame_pos;
  logic [31:0]                  frame_seq;
  logic [31:0]                  frame_check;
  logic [31:0]                  frame_crc;

  // Reflected CRC-32, one data bit at a time.
  function automatic logic [31:0] crc_step(logic [31:0] acc, logic [7:0] b);
    logic [31:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) begin
        r = {1'b0, r[31:1]} ^ crc32fc_pkg::CrcPoly;
      end else begin
        r = {1'b0, r[31:1]};
      end
    end
    return r;
  endfunction

  task automatic clear_frame_state();
    frame_pos   = '0;
    frame_seq   = '0;
    frame_check = '0;
    frame_crc   = crc32fc_pkg::CrcInit;
  endtask

  // Advances the shadow state by one accepted byte; a last byte yields a verdict.
  task automatic predict_byte(input logic [7:0] b, input logic last);
    verdict_rec_t v;
    if (32'(frame_pos) < crc32fc_pkg::SeqBytes) begin
      frame_seq[8*frame_pos[1:0] +: 8] = b;
    end else if (32'(frame_pos) < crc32fc_pkg::HeaderBytes) begin
      frame_check[8*frame_pos[1:0] +: 8] = b;
    end else if (32'(frame_pos) - crc32fc_pkg::HeaderBytes < crc32fc_pkg::MaxPayload) begin
      frame_crc = crc_step(frame_crc, b);
    end
    if (32'(frame_pos) < crc32fc_pkg::PosLimit) begin
      frame_pos = frame_pos + crc32fc_pkg::PosW'(1);
    end
    if (last) begin
      if (32'(frame_pos) < crc32fc_pkg::HeaderBytes) begin
        v.verdict = crc32fc_pkg::VerdictShort;
        v.seq     = '0;
        v.len     = '0;
      end else if (32'(frame_pos) - crc32fc_pkg::HeaderBytes > crc32fc_pkg::MaxPayload) begin
        v.verdict = crc32fc_pkg::VerdictLong;
        v.seq     = frame_seq;
        v.len     = crc32fc_pkg::PayLenW'(crc32fc_pkg::MaxPayload);
      end else begin
        v.seq     = frame_seq;
        v.len     = crc32fc_pkg::PayLenW'(32'(frame_pos) - crc32fc_pkg::HeaderBytes);
        v.verdict = (~frame_crc == frame_check) ? crc32fc_pkg::VerdictAccept
                                                : crc32fc_pkg::VerdictMismatch;
      end
      expected_verdicts.push_back(v);
      clear_frame_state();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    failures++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    pending_bytes.push_back(frame_byte_t'{b, last});
    bytes_outstanding++;
    queued_total++;
  endtask

  // Good and bad-CRC frames take len as the payload length; short and noise
  // frames take it as the total byte count.
  task automatic queue_frame(input frame_kind_e kind, input int unsigned len,
                             input logic [31:0] seq);
    logic [7:0]  payload[$];
    logic [31:0] acc;
    logic [31:0] check;
    acc = crc32fc_pkg::CrcInit;
    case (kind)
      FrameGood, FrameBadCrc: begin
        for (int i = 0; i < len; i++) begin
          payload.push_back(8'($urandom));
          acc = crc_step(acc, payload[i]);
        end
        check = ~acc;
        if (kind == FrameBadCrc) begin
          check ^= 32'd1 << $urandom_range(31);
        end
        for (int i = 0; i < 4; i++) begin
          push_byte(seq[8*i +: 8], 1'b0);
        end
        for (int i = 0; i < 4; i++) begin
          push_byte(check[8*i +: 8], (len == 0) && (i == 3));
        end
        for (int i = 0; i < len; i++) begin
          push_byte(payload[i], i == len - 1);
        end
      end
      FrameShort: begin
        for (int i = 0; i < len; i++) begin
          push_byte(8'($urandom), i == len - 1);
        end
      end
      default: begin
        // Random bytes with frame ends sprinkled in, always closed at the end.
        for (int i = 0; i < len; i++) begin
          push_byte(8'($urandom), (i == len - 1) || ($urandom_range(5) == 0));
        end
      end
    endcase
  endtask

  task automatic wait_drained();
    while (bytes_outstanding != 0 || expected_verdicts.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Clock, reset, and known levels on every input from time zero.
  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.rx_byte    = '0;
    in_if.frame_end  = 1'b0;
    out_if.ready     = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Byte driver: presents the next pending byte and holds it until taken.
  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    frame_byte_t nxt;
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.rx_byte   <= '0;
      in_if.frame_end <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_byte(in_if.rx_byte, in_if.frame_end);
        bytes_outstanding--;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_bytes.pop_front();
          in_if.valid     <= 1'b1;
          in_if.rx_byte   <= nxt.data;
          in_if.frame_end <= nxt.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Verdict monitor: checks each transaction against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : verdict_monitor
    verdict_rec_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("verdict with no frame pending", 32'(out_if.verdict), 32'd0);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_if.verdict !== want.verdict) begin
            report_mismatch("verdict", 32'(out_if.verdict), 32'(want.verdict));
          end
          if (out_if.ack_sequence !== want.seq) begin
            report_mismatch("ack_sequence", out_if.ack_sequence, want.seq);
          end
          if (out_if.payload_bytes !== want.len) begin
            report_mismatch("payload_bytes", 32'(out_if.payload_bytes), 32'(want.len));
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Ends the run if neither channel moves a transaction for too long.
  always @(posedge clk_i or negedge rst_ni) begin : watchdog
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("Watchdog expired at %0t", $realtime);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int start;
    int unsigned r;
    bytes_outstanding = 0;
    queued_total      = 0;
    failures          = 0;
    send_idle_pct     = 17;
    recv_idle_pct     = 48;
    clear_frame_state();

    // Directed frames: a lone byte, an empty payload whose checksum is zero,
    // a one-byte payload under an all-zero sequence number, and a frame one
    // byte short.
    queue_frame(FrameShort, 1, '0);
    queue_frame(FrameGood, 0, 32'hFFFF_FFFF);
    queue_frame(FrameGood, 1, 32'h0000_0000);
    queue_frame(FrameShort, 7, '0);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      start = queued_total;
      while (queued_total - start < PhaseBudget) begin
        r = $urandom_range(99);
        if (r < 70) begin
          queue_frame(FrameGood, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24),
                      $urandom);
        end else if (r < 85) begin
          queue_frame(FrameBadCrc, $urandom_range(0, 16), $urandom);
        end else if (r < 93) begin
          queue_frame(FrameShort, $urandom_range(1, 7), '0);
        end else begin
          queue_frame(FrameNoise, $urandom_range(1, 20), '0);
        end
      end
      // One oversized frame early on, up to and past the counter's saturation point.
      if (p == 0) begin
        queue_frame(FrameGood, crc32fc_pkg::MaxPayload + $urandom_range(1, 16), $urandom);
      end
      // Hold off the next phase until the unit has answered every frame.
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
